/* hw/rtl/pfpl_pkg.sv */
package pfpl_pkg;
   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 32;
   localparam int PIN_BITS  = 8;
   localparam int FIDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_BITS  = $clog2(FRAMES + 1);
   localparam int LIM_BITS  = 5;

   localparam logic [2:0] OP_FETCH   = 3'd0;
   localparam logic [2:0] OP_INSTALL = 3'd1;
   localparam logic [2:0] OP_UNPIN   = 3'd2;
   localparam logic [2:0] OP_DELETE  = 3'd3;
   localparam logic [2:0] OP_FLUSH   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_ALLPINNED = 3'd2;
   localparam logic [2:0] ST_PINNED    = 3'd3;
   localparam logic [2:0] ST_NOTRES    = 3'd4;
   localparam logic [2:0] ST_UNDERFLOW = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [PAGE_BITS-1:0] page_number;
      logic                 mark_dirty;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [3:0]           frame_index;
      logic                 was_resident;
      logic                 load_needed;
      logic                 evicted;
      logic                 writeback;
      logic [PAGE_BITS-1:0] writeback_page;
   } rsp_type;

   // frame directory cell state
   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic [PIN_BITS-1:0]  pins;
      logic                 dirty;
   } frame_type;

   // command broadcast to frame cells on update
   typedef struct packed {
      logic                 wr;
      logic [FIDX_BITS-1:0] idx;
      frame_type            data;
   } fcmd_type;
endpackage

/* hw/rtl/pfpl_if.sv */
interface pfpl_req_if;
   import pfpl_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, payload, input ready);
   modport sink   (input valid, payload, output ready);
endinterface

interface pfpl_rsp_if;
   import pfpl_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, payload, input ready);
   modport sink   (input valid, payload, output ready);
endinterface

interface pfpl_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] payload;
   modport source (output valid, payload, input ready);
   modport sink   (input valid, payload, output ready);
endinterface

/* hw/rtl/pfpl_frame_cell.sv */
module pfpl_frame_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pfpl_pkg::FIDX_BITS-1:0] my_idx,
   input  pfpl_pkg::fcmd_type         cmd,
   input  logic [pfpl_pkg::PAGE_BITS-1:0] key,
   output pfpl_pkg::frame_type        state,
   output logic                       hit
);
   import pfpl_pkg::*;
   frame_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      if (cmd.wr && cmd.idx == my_idx) st_in = cmd.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
         st_ff.pins  <= '0;
         st_ff.dirty <= 1'b0;
      end else begin
         st_ff.valid <= st_in.valid;
         st_ff.pins  <= st_in.pins;
         st_ff.dirty <= st_in.dirty;
      end
      st_ff.page <= st_in.page;
   end

   assign state = st_ff;
   assign hit   = st_ff.valid && st_ff.page == key;
endmodule

/* hw/rtl/pfpl_queue_cell.sv */
// one slot of the unpinned queue; compacts by taking its right neighbour
module pfpl_queue_cell (
   input  logic                           clock,
   input  logic                           occ_left,
   input  logic [pfpl_pkg::FIDX_BITS-1:0] ent_right,
   input  logic                           shift,
   input  logic                           load,
   input  logic [pfpl_pkg::FIDX_BITS-1:0] load_val,
   output logic [pfpl_pkg::FIDX_BITS-1:0] ent
);
   import pfpl_pkg::*;
   logic [FIDX_BITS-1:0] ent_ff, ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (load) ent_in = load_val;
      else if (shift && occ_left) ent_in = ent_right;
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;
endmodule

/* hw/rtl/page_frame_pool_lru.sv */
// channel | dir | ports | content
// req     | in  | req_  | opcode, page_number, mark_dirty
// rsp     | out | rsp_  | status, frame_index, was_resident, load_needed,
//         |     |       | evicted, writeback, writeback_page
// csr     | in  | csr_  | frames_in_use
// One item at a time: lookup and decide, then a queue scan one slot a cycle.
// One that takes its frame out of the unpinned queue adds the scan, and an unpin
// to zero pins adds an append after it.
// Reset is synchronous; directory and queue empty, frames_in_use 16.
// A held result stalls acceptance of the next item.
module page_frame_pool_lru (
   input logic   clock,
   input logic   reset,
   pfpl_req_if.sink   req,
   pfpl_rsp_if.source rsp,
   pfpl_csr_if.sink   csr
);
   import pfpl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_REM  = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0]           state_ff;
   req_type              item_ff;
   logic [LIM_BITS-1:0]  lim_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [FIDX_BITS-1:0] rem_ff;   // frame to remove from queue
   logic                 push_ff;
   logic [CNT_BITS-1:0]  pos_ff;   // compaction scan position
   logic                 rv_ff;
   rsp_type              rsp_ff;

   frame_type            fst [FRAMES];
   logic [FRAMES-1:0]    hits;
   logic [FIDX_BITS-1:0] qent [FRAMES];
   fcmd_type             cmd;

   // compaction: slots from first match onward take right neighbour
   logic [FRAMES-1:0] qshift, qload;
   logic [FRAMES-1:0] qocc;

   genvar g;
   generate
      for (g = 0; g < FRAMES; g++) begin : g_cells
         pfpl_frame_cell u_fc (
            .clock(clock), .reset(reset), .my_idx(FIDX_BITS'(g)), .cmd(cmd),
            .key(item_ff.page_number), .state(fst[g]), .hit(hits[g]));
         pfpl_queue_cell u_qc (
            .clock(clock), .occ_left(qocc[g]),
            .ent_right((g == FRAMES-1) ? qent[g] : qent[(g+1) % FRAMES]),
            .shift(qshift[g]), .load(qload[g]), .load_val(rem_ff),
            .ent(qent[g]));
         assign qocc[g] = 1'b1;
      end
   endgenerate

   // lookup
   logic                 hit_any;
   logic [FIDX_BITS-1:0] hit_idx;
   logic                 free_any;
   logic [FIDX_BITS-1:0] free_idx;
   logic [LIM_BITS-1:0]  lim_eff;
   always_comb begin
      hit_any = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
      lim_eff = (lim_ff == '0) ? LIM_BITS'(1)
              : (lim_ff > LIM_BITS'(FRAMES)) ? LIM_BITS'(FRAMES) : lim_ff;
      for (int i = FRAMES-1; i >= 0; i--) begin
         if (hits[i]) begin hit_any = 1'b1; hit_idx = FIDX_BITS'(i); end
         if (!fst[i].valid && LIM_BITS'(i) < lim_eff) begin
            free_any = 1'b1; free_idx = FIDX_BITS'(i);
         end
      end
   end

   logic invalid;
   assign invalid = &item_ff.page_number;

   // decision
   rsp_type  r;
   fcmd_type c;
   logic     do_rem, do_push;
   logic [FIDX_BITS-1:0] rem_idx;
   frame_type hf, vf;
   logic [FIDX_BITS-1:0] v;
   always_comb begin
      r = '0; c = '0; do_rem = 1'b0; do_push = 1'b0; rem_idx = '0;
      hf = fst[hit_idx];
      v  = free_any ? free_idx : qent[0];
      vf = fst[v];
      case (item_ff.opcode)
         OP_FETCH, OP_INSTALL: begin
            if (invalid) r.status = ST_INVALID;
            else if (hit_any) begin
               r.was_resident = 1'b1; r.frame_index = 4'(hit_idx);
               if (hf.pins == PIN_MAX) r.status = ST_OVERFLOW;
               else begin
                  c.wr = 1'b1; c.idx = hit_idx; c.data = hf;
                  c.data.pins = hf.pins + 1'b1;
                  do_rem = 1'b1; rem_idx = hit_idx;
               end
            end else if (!free_any && cnt_ff == '0) r.status = ST_ALLPINNED;
            else begin
               if (vf.valid) begin
                  r.evicted = 1'b1;
                  if (vf.dirty) begin
                     r.writeback = 1'b1; r.writeback_page = vf.page;
                  end
               end
               c.wr = 1'b1; c.idx = v;
               c.data.valid = 1'b1; c.data.page = item_ff.page_number;
               c.data.pins = PIN_BITS'(1); c.data.dirty = 1'b0;
               do_rem = 1'b1; rem_idx = v;
               r.frame_index = 4'(v);
               r.load_needed = (item_ff.opcode == OP_FETCH);
            end
         end
         OP_UNPIN: begin
            if (!hit_any) r.status = ST_NOTRES;
            else begin
               r.was_resident = 1'b1; r.frame_index = 4'(hit_idx);
               if (hf.pins == '0) r.status = ST_UNDERFLOW;
               else begin
                  c.wr = 1'b1; c.idx = hit_idx; c.data = hf;
                  c.data.dirty = hf.dirty | item_ff.mark_dirty;
                  c.data.pins = hf.pins - 1'b1;
                  if (hf.pins == PIN_BITS'(1)) begin
                     do_rem = 1'b1; do_push = 1'b1; rem_idx = hit_idx;
                  end
               end
            end
         end
         OP_DELETE: begin
            if (invalid) r.status = ST_INVALID;
            else if (hit_any) begin
               r.was_resident = 1'b1; r.frame_index = 4'(hit_idx);
               if (hf.pins != '0) r.status = ST_PINNED;
               else begin
                  c.wr = 1'b1; c.idx = hit_idx; c.data = hf;
                  c.data.valid = 1'b0; c.data.dirty = 1'b0;
                  do_rem = 1'b1; rem_idx = hit_idx;
               end
            end
         end
         default: begin
            if (!hit_any) r.status = ST_NOTRES;
            else begin
               r.was_resident = 1'b1; r.frame_index = 4'(hit_idx);
               if (hf.dirty) begin
                  r.writeback = 1'b1; r.writeback_page = hf.page;
                  c.wr = 1'b1; c.idx = hit_idx; c.data = hf;
                  c.data.dirty = 1'b0;
               end
            end
         end
      endcase
      if (state_ff != S_LOOK) c.wr = 1'b0;
   end
   assign cmd = c;

   // removal walk: at position pos, if entry matches, drop it (shift rest)
   logic pos_in_range;
   logic [FIDX_BITS-1:0] pos_idx;
   logic match;
   assign pos_in_range = pos_ff < cnt_ff;
   assign pos_idx = pos_ff[FIDX_BITS-1:0];
   assign match = pos_in_range && qent[pos_idx] == rem_ff;
   always_comb begin
      qshift = '0; qload = '0;
      if (state_ff == S_REM && match)
         for (int i = 0; i < FRAMES; i++)
            qshift[i] = (CNT_BITS'(i) >= pos_ff) && (CNT_BITS'(i) < cnt_ff - 1'b1);
      if (state_ff == S_PUSH && cnt_ff < CNT_BITS'(FRAMES))
         for (int i = 0; i < FRAMES; i++)
            qload[i] = (CNT_BITS'(i) == cnt_ff);
   end

   logic rsp_free;
   assign rsp_free = !rv_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && rsp_free;
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; lim_ff <= LIM_BITS'(16); cnt_ff <= '0;
         rv_ff <= 1'b0; push_ff <= 1'b0; pos_ff <= '0;
      end else begin
         if (csr.valid) lim_ff <= csr.payload;
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready && req.payload.opcode <= OP_FLUSH)
                  state_ff <= S_LOOK;
            end
            S_LOOK: begin
               rv_ff <= 1'b1; rsp_ff <= r;
               rem_ff <= rem_idx; push_ff <= do_push; pos_ff <= '0;
               state_ff <= do_rem ? S_REM : S_IDLE;
            end
            S_REM: begin
               if (match) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  state_ff <= push_ff ? S_PUSH : S_IDLE;
               end else if (!pos_in_range) begin
                  state_ff <= push_ff ? S_PUSH : S_IDLE;
               end else pos_ff <= pos_ff + 1'b1;
            end
            default: begin
               if (cnt_ff < CNT_BITS'(FRAMES)) cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (req.valid && req.ready) item_ff <= req.payload;
   end
endmodule

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pfpl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   always #6 clock = ~clock;

   pfpl_req_if req ();
   pfpl_rsp_if rsp ();
   pfpl_csr_if csr ();

   page_frame_pool_lru uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // pool model
   logic                 pool_valid [FRAMES];
   logic [PAGE_BITS-1:0] pool_page  [FRAMES];
   logic [PIN_BITS-1:0]  pool_pins  [FRAMES];
   logic                 pool_dirty [FRAMES];
   int                   lru_order[$];
   int                   pool_limit = 16;

   rsp_type expected_rsps[$];
   int      rsp_seen = 0;
   int      hits = 0, evictions = 0, writebacks = 0;
   bit      idle_on = 1'b1;
   int      hold_off = 0;

   typedef struct {
      req_type item;
      bit      known;
      rsp_type rsp;
   } row_type;

   function automatic int find_frame(logic [PAGE_BITS-1:0] pg);
      for (int f = 0; f < FRAMES; f++)
         if (pool_valid[f] && pool_page[f] == pg) return f;
      return -1;
   endfunction

   function automatic void lru_drop(int f);
      for (int i = lru_order.size() - 1; i >= 0; i--)
         if (lru_order[i] == f) lru_order.delete(i);
   endfunction

   function automatic bit pool_step(req_type it, output rsp_type r);
      int f, v, lim;
      bit bad;
      r = '0;
      if (it.opcode > OP_FLUSH) return 1'b0;
      bad = (it.page_number == '1);
      f = find_frame(it.page_number);
      case (it.opcode)
         OP_FETCH, OP_INSTALL: begin
            if (bad) r.status = ST_INVALID;
            else if (f >= 0) begin
               r.was_resident = 1'b1;
               r.frame_index = f[3:0];
               if (pool_pins[f] == PIN_MAX) r.status = ST_OVERFLOW;
               else begin
                  pool_pins[f]++;
                  lru_drop(f);
               end
            end else begin
               v = -1;
               lim = (pool_limit == 0) ? 1 : (pool_limit > FRAMES ? FRAMES : pool_limit);
               for (int i = 0; i < lim; i++)
                  if (v < 0 && !pool_valid[i]) v = i;
               if (v < 0 && lru_order.size() > 0) v = lru_order[0];
               if (v < 0) r.status = ST_ALLPINNED;
               else begin
                  if (pool_valid[v]) begin
                     r.evicted = 1'b1;
                     if (pool_dirty[v]) begin
                        r.writeback = 1'b1;
                        r.writeback_page = pool_page[v];
                     end
                  end
                  lru_drop(v);
                  pool_valid[v] = 1'b1;
                  pool_page[v] = it.page_number;
                  pool_pins[v] = 1;
                  pool_dirty[v] = 1'b0;
                  r.frame_index = v[3:0];
                  r.load_needed = (it.opcode == OP_FETCH);
               end
            end
         end
         OP_UNPIN: begin
            if (f < 0) r.status = ST_NOTRES;
            else begin
               r.was_resident = 1'b1;
               r.frame_index = f[3:0];
               if (pool_pins[f] == 0) r.status = ST_UNDERFLOW;
               else begin
                  if (it.mark_dirty) pool_dirty[f] = 1'b1;
                  pool_pins[f]--;
                  if (pool_pins[f] == 0) begin
                     lru_drop(f);
                     lru_order = {lru_order, f};
                  end
               end
            end
         end
         OP_DELETE: begin
            if (bad) r.status = ST_INVALID;
            else if (f >= 0) begin
               r.was_resident = 1'b1;
               r.frame_index = f[3:0];
               if (pool_pins[f] != 0) r.status = ST_PINNED;
               else begin
                  lru_drop(f);
                  pool_valid[f] = 1'b0;
                  pool_dirty[f] = 1'b0;
               end
            end
         end
         default: begin
            if (f < 0) r.status = ST_NOTRES;
            else begin
               r.was_resident = 1'b1;
               r.frame_index = f[3:0];
               if (pool_dirty[f]) begin
                  r.writeback = 1'b1;
                  r.writeback_page = pool_page[f];
                  pool_dirty[f] = 1'b0;
               end
            end
         end
      endcase
      return 1'b1;
   endfunction

   task automatic send_item(req_type it, bit known = 1'b0, rsp_type want = '0);
      rsp_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (pool_step(it, r)) begin
         if (known && r !== want) begin
            $error("predicted rsp exp %h got %h", want, r);
            errors++;
         end
         if (known) expected_rsps = {expected_rsps, want};
         else expected_rsps = {expected_rsps, r};
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_limit(logic [4:0] v);
      csr.valid <= 1'b1;
      csr.payload <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      pool_limit = v;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic req_type mk(logic [2:0] op, logic [31:0] pg, logic d = 1'b0);
      req_type it;
      it.opcode = op;
      it.page_number = pg;
      it.mark_dirty = d;
      return it;
   endfunction

   function automatic rsp_type mkr(logic [2:0] st, logic [3:0] fi = 0, logic res = 0,
                                   logic ld = 0);
      rsp_type r;
      r = '0;
      r.status = st;
      r.frame_index = fi;
      r.was_resident = res;
      r.load_needed = ld;
      return r;
   endfunction

   // random page from a small pool so hits and evictions happen
   function automatic logic [31:0] pick_page();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF;
         2: return 32'hFFFF_FFFE;
         default: return 32'hA5A5_0000 + $urandom_range(0, 23);
      endcase
   endfunction

   initial begin
      row_type rows[$];
      req_type it;
      logic [4:0] limits[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
      for (int f = 0; f < FRAMES; f++) begin
         pool_valid[f] = 0; pool_page[f] = 0; pool_pins[f] = 0; pool_dirty[f] = 0;
      end
      req.valid = 1'b0; req.payload = '0;
      csr.valid = 1'b0; csr.payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows = '{
         '{mk(OP_FETCH, 32'hFFFF_FFFF), 1, mkr(ST_INVALID)},
         '{mk(OP_UNPIN, 32'h5), 1, mkr(ST_NOTRES)},
         '{mk(OP_FLUSH, 32'hFFFF_FFFF), 1, mkr(ST_NOTRES)},
         '{mk(OP_DELETE, 32'h5), 1, mkr(ST_OK)},
         '{mk(OP_DELETE, 32'hFFFF_FFFF), 1, mkr(ST_INVALID)},
         '{mk(OP_FETCH, 32'h0), 1, mkr(ST_OK, 0, 0, 1)},
         '{mk(OP_INSTALL, 32'hFFFF_FFFE), 1, mkr(ST_OK, 1)},
         '{mk(OP_INSTALL, 32'h0), 1, mkr(ST_OK, 0, 1)},
         '{mk(OP_DELETE, 32'h0), 1, mkr(ST_PINNED, 0, 1)},
         '{mk(OP_UNPIN, 32'h0, 1'b1), 0, '0},
         '{mk(OP_UNPIN, 32'h0, 1'b1), 0, '0},
         '{mk(OP_UNPIN, 32'h0), 1, mkr(ST_UNDERFLOW, 0, 1)},
         '{mk(OP_FLUSH, 32'h0), 0, '0},
         '{mk(OP_FLUSH, 32'h0), 0, '0},
         '{mk(3'd5, 32'h0), 0, '0},
         '{mk(3'd7, 32'hFFFF_FFFF, 1'b1), 0, '0},
         '{mk(OP_UNPIN, 32'hFFFF_FFFE, 1'b1), 0, '0},
         '{mk(OP_DELETE, 32'hFFFF_FFFE), 0, '0},
         '{mk(OP_DELETE, 32'h0), 0, '0}
      };
      foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].rsp);
      // pin overflow on one page
      for (int i = 0; i < 257; i++) send_item(mk(OP_FETCH, 32'h0000_0077));
      drain();

      foreach (limits[k]) begin
         write_limit(limits[k]);
         if (k == 1) begin
            hold_off = 200;
            idle_on = 1'b0;
         end
         for (int n = 0; n < 20; n++) begin
            if (k == 5 && n == 10) idle_on = 1'b0;
            else if (k != 5 && k != 1) idle_on = 1'b1;
            it.page_number = pick_page();
            it.mark_dirty = $urandom_range(0, 1);
            case ($urandom_range(0, 19))
               0: it.opcode = 3'($urandom_range(5, 7));
               1, 2, 3, 4, 5, 6, 7: it.opcode = OP_FETCH;
               8, 9: it.opcode = OP_INSTALL;
               10, 11, 12, 13, 14, 15: it.opcode = OP_UNPIN;
               16, 17: it.opcode = OP_DELETE;
               default: it.opcode = OP_FLUSH;
            endcase
            send_item(it);
         end
         drain();
      end
      $display("tb_top: %0d results checked; %0d hits, %0d evictions, %0d writebacks",
               rsp_seen, hits, evictions, writebacks);
      $display("tb_top: frame limits 16,1,0,31,4,9 exercised with pin overflow and stalls");
      if (errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   // response sink with random stalls and one long hold-off
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp.ready <= 1'b0;
            hold_off--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else
            rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected item %h", rsp.payload);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp.payload.was_resident) hits++;
            if (rsp.payload.evicted) evictions++;
            if (rsp.payload.writeback) writebacks++;
            if (rsp.payload.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp.payload.status); errors++;
            end
            if (rsp.payload.frame_index !== want.frame_index) begin
               $error("frame_index exp %0d got %0d", want.frame_index,
                      rsp.payload.frame_index); errors++;
            end
            if (rsp.payload.was_resident !== want.was_resident) begin
               $error("was_resident exp %0b got %0b", want.was_resident,
                      rsp.payload.was_resident); errors++;
            end
            if (rsp.payload.load_needed !== want.load_needed) begin
               $error("load_needed exp %0b got %0b", want.load_needed,
                      rsp.payload.load_needed); errors++;
            end
            if (rsp.payload.evicted !== want.evicted) begin
               $error("evicted exp %0b got %0b", want.evicted, rsp.payload.evicted); errors++;
            end
            if (rsp.payload.writeback !== want.writeback) begin
               $error("writeback exp %0b got %0b", want.writeback, rsp.payload.writeback);
               errors++;
            end
            if (rsp.payload.writeback_page !== want.writeback_page) begin
               $error("writeback_page exp %h got %h", want.writeback_page,
                      rsp.payload.writeback_page); errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
